[rtl/snz_pkg.sv]
package snz_pkg;

    // permutation table geometry
    localparam int TBL_SIZE = 256;
    localparam int TBL_AW   = 8;

    // result format
    localparam int NOISE_W  = 18;
    localparam int OUT_FRAC = 16;
    localparam int NOISE_MAX = 65536;

    // skew and unskew factors in Q0.32, rounded later to the working precision
    localparam longint unsigned F2_Q32 = 64'd1572067139;
    localparam longint unsigned G2_Q32 = 64'd907633386;

    // number of gradient vectors
    localparam int GRAD_N = 12;

    // one gradient vector, components in -1..1
    typedef struct packed {
        logic signed [1:0] gx;
        logic signed [1:0] gy;
    } t_grad;

    // the diagonal vectors first, then the axis vectors, each axis vector listed twice
    function automatic t_grad snz_grad(input logic [3:0] g);
        t_grad v;
        case (g)
            4'd0:    v = '{gx:  2'sd1, gy:  2'sd1};
            4'd1:    v = '{gx: -2'sd1, gy:  2'sd1};
            4'd2:    v = '{gx:  2'sd1, gy: -2'sd1};
            4'd3:    v = '{gx: -2'sd1, gy: -2'sd1};
            4'd4:    v = '{gx:  2'sd1, gy:  2'sd0};
            4'd5:    v = '{gx: -2'sd1, gy:  2'sd0};
            4'd6:    v = '{gx:  2'sd1, gy:  2'sd0};
            4'd7:    v = '{gx: -2'sd1, gy:  2'sd0};
            4'd8:    v = '{gx:  2'sd0, gy:  2'sd1};
            4'd9:    v = '{gx:  2'sd0, gy: -2'sd1};
            4'd10:   v = '{gx:  2'sd0, gy:  2'sd1};
            4'd11:   v = '{gx:  2'sd0, gy: -2'sd1};
            default: v = '{gx:  2'sd0, gy:  2'sd0};
        endcase
        return v;
    endfunction

    // byte modulo twelve by reciprocal multiply, quotient = v * 171 >> 11
    function automatic logic [3:0] snz_mod12(input logic [7:0] v);
        logic [15:0] prod;
        logic [7:0]  quot;
        logic [7:0]  rem;
        prod = 16'(v) * 16'd171;
        quot = {3'b000, prod[15:11]};
        rem  = v - ((quot << 3) + (quot << 2));
        return rem[3:0];
    endfunction

endpackage

[rtl/simplex_noise_2d_top.sv]
// channel  | valid    | stall    | payload
// request  | i_valid  | o_stall  | i_opcode i_coord_x i_coord_y i_table_index i_table_value
// result   | o_valid  | i_stall  | o_noise_value
//
// one request per cycle while o_stall is low
// the rate is set by the six permutation table copies, one read port each,
// read in two levels at the third and fourth stages
// reset clears the stage valid bits; the table holds nothing until loaded
// a stalled result freezes the whole pipeline, load writes included
module simplex_noise_2d_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_opcode,
    input  logic signed [31:0]                   i_coord_x,
    input  logic signed [31:0]                   i_coord_y,
    input  logic [snz_pkg::TBL_AW-1:0]           i_table_index,
    input  logic [snz_pkg::TBL_AW-1:0]           i_table_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [snz_pkg::NOISE_W-1:0]   o_noise_value
);

    import snz_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int P_W   = 34 + F;
    localparam int I_W   = 34 - F;
    localparam int T_W   = I_W + F + 2;
    localparam int D_W   = 39;
    localparam int SQ_W  = 2 * F + 2;
    localparam int R_W   = 2 * F + 4;
    localparam int DT_W  = F + 2;
    localparam int M_W   = 2 * F + 3;
    localparam int TR_W  = F + 3;
    localparam int SU_W  = F + 5;
    localparam int SCL_W = F + 12;
    localparam int SH_L  = (F < OUT_FRAC) ? OUT_FRAC - F : 0;
    localparam int SH_R  = (F > OUT_FRAC) ? F - OUT_FRAC : 0;
    localparam int SC_W  = SCL_W + SH_L;
    localparam int N_RAM = 6;

    localparam logic [F:0] F2_C = (F+1)'((F2_Q32 + (64'd1 << (31 - F))) >> (32 - F));
    localparam logic [F:0] G2_C = (F+1)'((G2_Q32 + (64'd1 << (31 - F))) >> (32 - F));
    localparam logic signed [D_W-1:0] G2_D  = D_W'(G2_C);
    localparam logic signed [D_W-1:0] ONE_D = D_W'(1) << F;
    localparam logic signed [R_W-1:0] HALF_R = R_W'(1) << (2 * F - 1);
    localparam logic signed [SC_W-1:0] SAT_HI = SC_W'(NOISE_MAX);
    localparam logic signed [SC_W-1:0] SAT_LO = -SC_W'(NOISE_MAX);

    // pipeline advance: only a waiting, stalled result holds it
    logic en;
    logic r_out_vld;
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    // stage valid and opcode for the stages that still see loads
    logic [4:1] r_vld;
    logic [4:1] r_op;
    logic [13:5] r_ev;

    logic signed [31:0] r_s1_x, r_s1_y, r_s2_x, r_s2_y, r_s3_x, r_s3_y, r_s4_x, r_s4_y;
    logic [TBL_AW-1:0] r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx;
    logic [TBL_AW-1:0] r_s1_val, r_s2_val, r_s3_val, r_s4_val;
    logic signed [P_W-1:0] n_s2_p, r_s2_p;
    logic signed [I_W-1:0] n_s3_i, n_s3_j, r_s3_i, r_s3_j, r_s4_i, r_s4_j;
    logic signed [T_W-1:0] n_s4_t, r_s4_t;
    logic signed [D_W-1:0] n_s5_x0, n_s5_y0, r_s5_x0, r_s5_y0;
    logic [3:0] s5_g0, s5_g1a, s5_g1b, s5_g2;

    logic signed [D_W-1:0] n_s6_dx [3];
    logic signed [D_W-1:0] n_s6_dy [3];
    logic [3:0]            n_s6_g  [3];
    logic signed [D_W-1:0] r_s6_dx [3];
    logic signed [D_W-1:0] r_s6_dy [3];
    logic [3:0]            r_s6_g  [3];

    logic signed [SQ_W-1:0] n_s7_sqx [3];
    logic signed [SQ_W-1:0] n_s7_sqy [3];
    logic signed [F:0]      n_s7_dx  [3];
    logic signed [F:0]      n_s7_dy  [3];
    logic                   n_s7_far [3];
    logic signed [SQ_W-1:0] r_s7_sqx [3];
    logic signed [SQ_W-1:0] r_s7_sqy [3];
    logic signed [F:0]      r_s7_dx  [3];
    logic signed [F:0]      r_s7_dy  [3];
    logic                   r_s7_far [3];
    logic [3:0]             r_s7_g   [3];

    logic [F-1:0]           n_s8_t  [3];
    logic                   n_s8_z  [3];
    logic signed [DT_W-1:0] n_s8_d  [3];
    logic [F-1:0]           r_s8_t  [3];
    logic                   r_s8_z  [3];
    logic signed [DT_W-1:0] r_s8_d  [3];

    logic [F-1:0]           n_s9_t  [3];
    logic [F-1:0]           r_s9_t  [3];
    logic                   r_s9_z  [3];
    logic signed [DT_W-1:0] r_s9_d  [3];
    logic [F-1:0]           n_s10_t [3];
    logic [F-1:0]           r_s10_t [3];
    logic                   r_s10_z [3];
    logic signed [DT_W-1:0] r_s10_d [3];

    logic signed [TR_W-1:0] n_s11_trm [3];
    logic signed [TR_W-1:0] r_s11_trm [3];
    logic signed [SU_W-1:0] n_s12_sum, r_s12_sum;
    logic signed [SC_W-1:0] n_s13_sc, r_s13_sc;
    logic signed [NOISE_W-1:0] n_out, r_out;

    // permutation table copies: two first level reads, four second level reads
    logic [TBL_AW-1:0] ram_raddr [N_RAM];
    logic [TBL_AW-1:0] ram_q     [N_RAM];
    logic              we_lvl1, we_lvl2;

    assign we_lvl1 = en && r_vld[3] && !r_op[3];
    assign we_lvl2 = en && r_vld[4] && !r_op[4];

    assign ram_raddr[0] = r_s3_j[TBL_AW-1:0];
    assign ram_raddr[1] = r_s3_j[TBL_AW-1:0] + 1'b1;
    assign ram_raddr[2] = r_s4_i[TBL_AW-1:0] + ram_q[0];
    assign ram_raddr[3] = r_s4_i[TBL_AW-1:0] + ram_q[0] + 1'b1;
    assign ram_raddr[4] = r_s4_i[TBL_AW-1:0] + ram_q[1];
    assign ram_raddr[5] = r_s4_i[TBL_AW-1:0] + ram_q[1] + 1'b1;

    for (genvar k = 0; k < N_RAM; k++) begin : g_tbl
        snz_ram #(
            .WIDTH (TBL_AW),
            .DEPTH (TBL_SIZE)
        ) u_tbl (
            .i_clk   (i_clk),
            .i_we    ((k < 2) ? we_lvl1 : we_lvl2),
            .i_waddr ((k < 2) ? r_s3_idx : r_s4_idx),
            .i_wdata ((k < 2) ? r_s3_val : r_s4_val),
            .i_re    (en),
            .i_raddr (ram_raddr[k]),
            .o_rdata (ram_q[k])
        );
    end

    // gradient indices from the second level reads, valid at the fifth stage
    assign s5_g0  = snz_mod12(ram_q[2]);
    assign s5_g1a = snz_mod12(ram_q[3]);
    assign s5_g1b = snz_mod12(ram_q[4]);
    assign s5_g2  = snz_mod12(ram_q[5]);

    // skew, floor, unskew
    always_comb begin
        logic signed [32:0]  sxy;
        logic signed [P_W:0] xs, ys;
        logic signed [I_W:0] ij;
        sxy     = 33'(r_s1_x) + 33'(r_s1_y);
        n_s2_p  = P_W'(sxy * $signed(F2_C));
        xs      = (P_W+1)'(r_s2_x) + (P_W+1)'(r_s2_p >>> F);
        ys      = (P_W+1)'(r_s2_y) + (P_W+1)'(r_s2_p >>> F);
        n_s3_i  = I_W'(xs >>> F);
        n_s3_j  = I_W'(ys >>> F);
        ij      = (I_W+1)'(r_s3_i) + (I_W+1)'(r_s3_j);
        n_s4_t  = T_W'(ij * $signed(G2_C));
        n_s5_x0 = D_W'(r_s4_x) - (D_W'(r_s4_i) <<< F) + D_W'(r_s4_t);
        n_s5_y0 = D_W'(r_s4_y) - (D_W'(r_s4_j) <<< F) + D_W'(r_s4_t);
    end

    // corner order and offsets
    always_comb begin
        logic up;
        up = r_s5_x0 > r_s5_y0;
        n_s6_dx[0] = r_s5_x0;
        n_s6_dy[0] = r_s5_y0;
        n_s6_g[0]  = s5_g0;
        n_s6_dx[1] = r_s5_x0 - (up ? ONE_D : '0) + G2_D;
        n_s6_dy[1] = r_s5_y0 - (up ? '0 : ONE_D) + G2_D;
        n_s6_g[1]  = up ? s5_g1a : s5_g1b;
        n_s6_dx[2] = r_s5_x0 - ONE_D + (G2_D <<< 1);
        n_s6_dy[2] = r_s5_y0 - ONE_D + (G2_D <<< 1);
        n_s6_g[2]  = s5_g2;
    end

    // per corner falloff and gradient dot product
    always_comb begin
        t_grad                  gr;
        logic signed [R_W-1:0]  rr;
        logic [2*F-1:0]         p9, p10;
        logic signed [M_W-1:0]  m;
        logic signed [DT_W-1:0] ex, ey;
        for (int k = 0; k < 3; k++) begin
            n_s7_far[k] = (r_s6_dx[k] >= ONE_D) || (r_s6_dx[k] <= -ONE_D)
                       || (r_s6_dy[k] >= ONE_D) || (r_s6_dy[k] <= -ONE_D);
            n_s7_dx[k]  = r_s6_dx[k][F:0];
            n_s7_dy[k]  = r_s6_dy[k][F:0];
            n_s7_sqx[k] = SQ_W'(n_s7_dx[k] * n_s7_dx[k]);
            n_s7_sqy[k] = SQ_W'(n_s7_dy[k] * n_s7_dy[k]);

            rr          = HALF_R - R_W'(r_s7_sqx[k]) - R_W'(r_s7_sqy[k]);
            n_s8_z[k]   = r_s7_far[k] || (rr <= 0);
            n_s8_t[k]   = rr[2*F-1:F];
            gr          = snz_grad(r_s7_g[k]);
            ex          = DT_W'(r_s7_dx[k]);
            ey          = DT_W'(r_s7_dy[k]);
            n_s8_d[k]   = '0;
            if (gr.gx == 2'sd1) begin
                n_s8_d[k] = n_s8_d[k] + ex;
            end else if (gr.gx == -2'sd1) begin
                n_s8_d[k] = n_s8_d[k] - ex;
            end
            if (gr.gy == 2'sd1) begin
                n_s8_d[k] = n_s8_d[k] + ey;
            end else if (gr.gy == -2'sd1) begin
                n_s8_d[k] = n_s8_d[k] - ey;
            end

            p9           = (2*F)'(r_s8_t[k]) * (2*F)'(r_s8_t[k]);
            n_s9_t[k]    = p9[2*F-1:F];
            p10          = (2*F)'(r_s9_t[k]) * (2*F)'(r_s9_t[k]);
            n_s10_t[k]   = p10[2*F-1:F];

            m            = M_W'($signed({1'b0, r_s10_t[k]}) * r_s10_d[k]);
            n_s11_trm[k] = r_s10_z[k] ? '0 : m[M_W-1:F];
        end
    end

    // sum, scale by 70, align to the output format and saturate
    always_comb begin
        logic signed [SCL_W-1:0] scl;
        n_s12_sum = SU_W'(r_s11_trm[0]) + SU_W'(r_s11_trm[1]) + SU_W'(r_s11_trm[2]);
        scl       = (SCL_W'(r_s12_sum) <<< 6) + (SCL_W'(r_s12_sum) <<< 2)
                  + (SCL_W'(r_s12_sum) <<< 1);
        n_s13_sc  = (SC_W'(scl) <<< SH_L) >>> SH_R;
        if (r_s13_sc > SAT_HI) begin
            n_out = NOISE_W'(NOISE_MAX);
        end else if (r_s13_sc < SAT_LO) begin
            n_out = -NOISE_W'(NOISE_MAX);
        end else begin
            n_out = r_s13_sc[NOISE_W-1:0];
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_ev      <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[3:1], i_valid};
            r_ev      <= {r_ev[12:5], r_vld[4] && r_op[4]};
            r_out_vld <= r_ev[13];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op      <= {r_op[3:1], i_opcode};
            r_s1_x    <= i_coord_x;
            r_s1_y    <= i_coord_y;
            r_s1_idx  <= i_table_index;
            r_s1_val  <= i_table_value;
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_idx  <= r_s1_idx;
            r_s2_val  <= r_s1_val;
            r_s2_p    <= n_s2_p;
            r_s3_x    <= r_s2_x;
            r_s3_y    <= r_s2_y;
            r_s3_idx  <= r_s2_idx;
            r_s3_val  <= r_s2_val;
            r_s3_i    <= n_s3_i;
            r_s3_j    <= n_s3_j;
            r_s4_x    <= r_s3_x;
            r_s4_y    <= r_s3_y;
            r_s4_idx  <= r_s3_idx;
            r_s4_val  <= r_s3_val;
            r_s4_i    <= r_s3_i;
            r_s4_j    <= r_s3_j;
            r_s4_t    <= n_s4_t;
            r_s5_x0   <= n_s5_x0;
            r_s5_y0   <= n_s5_y0;
            for (int k = 0; k < 3; k++) begin
                r_s6_dx[k]   <= n_s6_dx[k];
                r_s6_dy[k]   <= n_s6_dy[k];
                r_s6_g[k]    <= n_s6_g[k];
                r_s7_sqx[k]  <= n_s7_sqx[k];
                r_s7_sqy[k]  <= n_s7_sqy[k];
                r_s7_dx[k]   <= n_s7_dx[k];
                r_s7_dy[k]   <= n_s7_dy[k];
                r_s7_far[k]  <= n_s7_far[k];
                r_s7_g[k]    <= r_s6_g[k];
                r_s8_t[k]    <= n_s8_t[k];
                r_s8_z[k]    <= n_s8_z[k];
                r_s8_d[k]    <= n_s8_d[k];
                r_s9_t[k]    <= n_s9_t[k];
                r_s9_z[k]    <= r_s8_z[k];
                r_s9_d[k]    <= r_s8_d[k];
                r_s10_t[k]   <= n_s10_t[k];
                r_s10_z[k]   <= r_s9_z[k];
                r_s10_d[k]   <= r_s9_d[k];
                r_s11_trm[k] <= n_s11_trm[k];
            end
            r_s12_sum <= n_s12_sum;
            r_s13_sc  <= n_s13_sc;
            if (!r_out_vld || !i_stall) begin
                r_out <= n_out;
            end
        end
    end

    assign o_valid       = r_out_vld;
    assign o_noise_value = r_out;

`ifndef SYNTHESIS
    // a load request never turns into a result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[4] && !r_op[4]) |=> !r_ev[5])
        else $error("load request entered the evaluate pipeline");

    // results stay inside plus or minus one
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_noise_value <= NOISE_W'(NOISE_MAX)
                  && o_noise_value >= -NOISE_W'(NOISE_MAX)))
        else $error("noise result outside saturation range");

    // a frozen pipeline issues no table write
    a_no_write_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (!we_lvl1 && !we_lvl2))
        else $error("table write while the pipeline is held");
`endif

endmodule

[rtl/snz_ram.sv]
module snz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sim/simplex_noise_2d_top_test.sv]
`timescale 1ns / 100ps

module simplex_noise_2d_top_test;
    import snz_pkg::*;

    localparam int FB = 16;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;
    localparam longint ONE = longint'(1) << FB;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic i_opcode;
    logic signed [31:0] i_coord_x;
    logic signed [31:0] i_coord_y;
    logic [TBL_AW-1:0] i_table_index;
    logic [TBL_AW-1:0] i_table_value;
    logic o_valid;
    logic i_stall;
    logic signed [NOISE_W-1:0] o_noise_value;

    typedef struct {
        logic op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [7:0] idx;
        logic [7:0] val;
    } t_request;

    logic [7:0] perm_copy [TBL_SIZE];
    logic signed [NOISE_W-1:0] noise_queue [$];
    int mismatches;
    bit quiet;

    simplex_noise_2d_top #(.FRAC_BITS(FB)) DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    // gradient components, indexed as in snz_grad of the package
    function automatic int grad_x(int g);
        int gxs [12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
        return gxs[g];
    endfunction

    function automatic int grad_y(int g);
        int gys [12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
        return gys[g];
    endfunction

    function automatic longint perm_read(longint k);
        return longint'(perm_copy[k[7:0]]);
    endfunction

    // one corner contribution, falloff to the fourth times gradient dot offset
    function automatic longint corner_share(longint dx, longint dy, int g);
        longint r, t, d;
        if (dx >= ONE || dx <= -ONE || dy >= ONE || dy <= -ONE) return 0;
        r = (longint'(1) << (2 * FB - 1)) - dx * dx - dy * dy;
        if (r <= 0) return 0;
        t = r >>> FB;
        t = (t * t) >>> FB;
        t = (t * t) >>> FB;
        d = grad_x(g) * dx + grad_y(g) * dy;
        return (t * d) >>> FB;
    endfunction

    // noise value at a Q15.16 point
    function automatic logic signed [NOISE_W-1:0] noise_at(logic signed [31:0] px,
                                                           logic signed [31:0] py);
        longint f2, g2, x, y, s, ci, cj, t, x0, y0, i1, j1, sum;
        int c0, c1, c2;
        f2 = longint'((F2_Q32 + (64'd1 << (31 - FB))) >> (32 - FB));
        g2 = longint'((G2_Q32 + (64'd1 << (31 - FB))) >> (32 - FB));
        x = longint'(px);
        y = longint'(py);
        s = ((x + y) * f2) >>> FB;
        ci = (x + s) >>> FB;
        cj = (y + s) >>> FB;
        t = (ci + cj) * g2;
        x0 = x - (ci * ONE - t);
        y0 = y - (cj * ONE - t);
        if (x0 > y0) begin
            i1 = 1; j1 = 0;
        end else begin
            i1 = 0; j1 = 1;
        end
        c0 = int'(perm_read(ci + perm_read(cj)) % 12);
        c1 = int'(perm_read(ci + i1 + perm_read(cj + j1)) % 12);
        c2 = int'(perm_read(ci + 1 + perm_read(cj + 1)) % 12);
        sum = corner_share(x0, y0, c0)
            + corner_share(x0 - i1 * ONE + g2, y0 - j1 * ONE + g2, c1)
            + corner_share(x0 - ONE + 2 * g2, y0 - ONE + 2 * g2, c2);
        sum = sum * 70;
        if (sum > NOISE_MAX) sum = NOISE_MAX;
        if (sum < -NOISE_MAX) sum = -NOISE_MAX;
        return sum[NOISE_W-1:0];
    endfunction

    // present one request and wait for its acceptance
    task automatic send_request(t_request rq);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_opcode = rq.op;
        i_coord_x = rq.x;
        i_coord_y = rq.y;
        i_table_index = rq.idx;
        i_table_value = rq.val;
        do @(posedge i_clk); while (o_stall);
        if (rq.op == OP_LOAD) begin
            perm_copy[rq.idx] = rq.val;
        end else begin
            noise_queue.push_back(noise_at(rq.x, rq.y));
        end
        @(negedge i_clk);
    endtask

    function automatic t_request load_req(int k, int v);
        t_request rq;
        rq.op = OP_LOAD;
        rq.x = $urandom;
        rq.y = $urandom;
        rq.idx = k[7:0];
        rq.val = v[7:0];
        return rq;
    endfunction

    function automatic t_request eval_req(logic signed [31:0] x, logic signed [31:0] y);
        t_request rq;
        rq.op = OP_EVAL;
        rq.x = x;
        rq.y = y;
        rq.idx = 8'($urandom);
        rq.val = 8'($urandom);
        return rq;
    endfunction

    // result stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_stall <= 1'b0;
        end else if (i_stall) begin
            if ($urandom_range(0, 2) == 0) i_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
        end
    end

    // compare each result with the oldest expected noise value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (noise_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d", o_noise_value);
            end else begin
                if (o_noise_value !== noise_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise mismatch: expected %0d, got %0d",
                                 noise_queue[0], o_noise_value);
                end
                void'(noise_queue.pop_front());
            end
        end
    end

    // stimulus
    initial begin
        t_request directed [$];
        int order [TBL_SIZE];
        int k, tmp, waited;
        logic signed [31:0] rx, ry;

        mismatches = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_LOAD;
        i_coord_x = '0;
        i_coord_y = '0;
        i_table_index = '0;
        i_table_value = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill the whole table with a shuffle before any evaluate
        foreach (order[n]) order[n] = n;
        for (int n = TBL_SIZE - 1; n > 0; n--) begin
            k = $urandom_range(0, n);
            tmp = order[n]; order[n] = order[k]; order[k] = tmp;
        end
        for (int n = 0; n < TBL_SIZE; n++) send_request(load_req(n, order[n]));

        // directed rows: field extremes, cell origin, index wrap, table extremes
        directed.push_back(eval_req(32'sh0000_0000, 32'sh0000_0000));
        directed.push_back(eval_req(32'sh7fff_ffff, 32'sh7fff_ffff));
        directed.push_back(eval_req(32'sh8000_0000, 32'sh8000_0000));
        directed.push_back(eval_req(32'sh7fff_ffff, 32'sh8000_0000));
        directed.push_back(eval_req(32'sh8000_0000, 32'sh7fff_ffff));
        directed.push_back(eval_req(32'sh0000_8000, 32'sh0000_4000));
        directed.push_back(eval_req(32'sh0000_4000, 32'sh0000_8000));
        directed.push_back(eval_req(32'shffff_ffff, 32'shffff_ffff));
        directed.push_back(eval_req(32'sh00ff_0000, 32'sh00ff_8000));
        directed.push_back(eval_req(32'shff00_3000, 32'sh0100_c000));
        directed.push_back(load_req(0, 255));
        directed.push_back(load_req(255, 0));
        directed.push_back(eval_req(32'sh0000_2000, 32'sh0000_1000));
        directed.push_back(eval_req(32'sh00ff_e000, 32'sh00ff_f000));
        directed.push_back(load_req(0, order[0]));
        directed.push_back(load_req(255, order[255]));
        directed.push_back(eval_req(32'sh0003_3333, 32'shfffc_cccd));
        directed.push_back(eval_req(32'sh0001_0000, 32'sh0000_0000));
        foreach (directed[n]) send_request(directed[n]);

        // random mix, mostly evaluates near the origin, some full range
        for (int n = 0; n < 380; n++) begin
            if (n > 320) quiet = 1'b1;
            k = $urandom_range(0, 19);
            if (k < 3) begin
                send_request(load_req($urandom_range(0, 255), $urandom_range(0, 255)));
            end else begin
                if (k < 7) begin
                    rx = $urandom;
                    ry = $urandom;
                end else begin
                    rx = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
                    ry = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
                end
                send_request(eval_req(rx, ry));
            end
        end
        i_valid = 1'b0;

        waited = 0;
        while (noise_queue.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && noise_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[simplex_noise_2d_top.f]
rtl/snz_pkg.sv
rtl/snz_ram.sv
rtl/simplex_noise_2d_top.sv
sim/simplex_noise_2d_top_test.sv
